/* design/circular_buffer_deque_defines.svh */
`ifndef CIRCULAR_BUFFER_DEQUE_DEFINES_SVH
`define CIRCULAR_BUFFER_DEQUE_DEFINES_SVH

// checked on every clock edge outside reset
`define CBD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// antecedent this cycle, consequent on the next edge
`define CBD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/cbd_pkg.sv */
`default_nettype none

package cbd_pkg;

  localparam int unsigned DEPTH      = 8;
  localparam int unsigned DATA_WIDTH = 32;
  localparam int unsigned IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [DATA_WIDTH-1:0] data_t;

  localparam idx_t LAST_IDX = idx_t'(DEPTH - 1);

  typedef enum logic [1:0] {
    MODE_PUSH_FRONT = 2'd0,
    MODE_PUSH_BACK  = 2'd1,
    MODE_POP_FRONT  = 2'd2,
    MODE_POP_BACK   = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_OVERFLOW  = 2'd1,
    STAT_UNDERFLOW = 2'd2
  } status_e;

  typedef struct packed {
    mode_e              mode;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    status_e            status;
    logic signed [31:0] popped;
    logic signed [31:0] head_value;
    logic signed [31:0] tail_value;
    logic               is_empty;
    logic               is_full;
  } out_item_t;

  typedef struct packed {
    logic  we;
    idx_t  waddr;
    data_t wdata;
    logic  re;
    idx_t  raddr;
  } mem_req_t;

  function automatic idx_t idx_inc(idx_t i);
    return (i == LAST_IDX) ? '0 : idx_t'(i + idx_t'(1));
  endfunction

  function automatic idx_t idx_dec(idx_t i);
    return (i == '0) ? LAST_IDX : idx_t'(i - idx_t'(1));
  endfunction

  function automatic logic signed [31:0] widen(data_t d);
    logic signed [63:0] ext;
    ext = 64'(signed'(d));
    return ext[31:0];
  endfunction

  function automatic data_t narrow(logic signed [31:0] v);
    logic signed [63:0] ext;
    ext = 64'(v);
    return ext[DATA_WIDTH-1:0];
  endfunction

endpackage

`default_nettype wire

/* design/cbd_mem.sv */
`default_nettype none

module cbd_mem
  import cbd_pkg::*;
(
  input  wire logic     clk_i,
  input  wire mem_req_t req_i,
  output data_t         rdata_o
);

  data_t mem_q [DEPTH];
  data_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* design/circular_buffer_deque.sv */
// Fixed-capacity double-ended queue over a circular slot RAM. Each input item is one of
// push front, push back, pop front or pop back, and yields exactly one result item with the
// status, the popped element, the front and back elements and the empty and full flags after
// the operation. Items are handled one at a time. Pushes, overflows, underflows and a pop of
// the last element load the result register directly; any other pop first reads the new
// front or back element from the single-port-read slot RAM, whose read data is registered,
// and then loads the result. Front and back elements are cached in registers, so
// only that one read is ever needed. The result sits in an output register, and the next item
// is accepted in the cycle that result is taken. The slot RAM needs no clearing after reset.
`default_nettype none

`include "circular_buffer_deque_defines.svh"

module circular_buffer_deque
  import cbd_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire in_item_t  in_item_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output out_item_t      out_item_o
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_READ = 2'b10
  } state_e;

  state_e    state_q, state_d;
  idx_t      head_q, head_d;
  idx_t      tail_q, tail_d;
  logic      empty_q, empty_d;
  data_t     hval_q, hval_d;
  data_t     tval_q, tval_d;
  data_t     popped_q, popped_d;
  logic      front_q, front_d;
  logic      out_valid_q, out_valid_d;
  out_item_t out_item_q, out_item_d;

  logic      in_fire;
  logic      out_load;
  logic      full_q;
  logic      full_d;
  logic      is_push;
  status_e   status_d;
  data_t     push_val;
  mem_req_t  mem_req;
  data_t     mem_rdata;

  cbd_mem u_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  assign in_ready_o = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);
  assign in_fire    = in_valid_i && in_ready_o;
  assign full_q     = !empty_q && (idx_inc(tail_q) == head_q);
  assign is_push    = (in_item_i.mode == MODE_PUSH_FRONT) || (in_item_i.mode == MODE_PUSH_BACK);
  assign push_val   = narrow(in_item_i.value);

  always_comb begin
    state_d  = state_q;
    head_d   = head_q;
    tail_d   = tail_q;
    empty_d  = empty_q;
    hval_d   = hval_q;
    tval_d   = tval_q;
    popped_d = '0;
    front_d  = front_q;
    status_d = STAT_OK;
    out_load = 1'b0;
    mem_req  = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (is_push) begin
            out_load = 1'b1;
            if (empty_q) begin
              head_d        = '0;
              tail_d        = '0;
              empty_d       = 1'b0;
              hval_d        = push_val;
              tval_d        = push_val;
              mem_req.we    = 1'b1;
              mem_req.waddr = '0;
              mem_req.wdata = push_val;
            end else if (full_q) begin
              status_d = STAT_OVERFLOW;
            end else if (in_item_i.mode == MODE_PUSH_FRONT) begin
              head_d        = idx_dec(head_q);
              hval_d        = push_val;
              mem_req.we    = 1'b1;
              mem_req.waddr = head_d;
              mem_req.wdata = push_val;
            end else begin
              tail_d        = idx_inc(tail_q);
              tval_d        = push_val;
              mem_req.we    = 1'b1;
              mem_req.waddr = tail_d;
              mem_req.wdata = push_val;
            end
          end else if (empty_q) begin
            status_d = STAT_UNDERFLOW;
            out_load = 1'b1;
          end else if (head_q == tail_q) begin
            popped_d = hval_q;
            head_d   = '0;
            tail_d   = '0;
            empty_d  = 1'b1;
            out_load = 1'b1;
          end else if (in_item_i.mode == MODE_POP_FRONT) begin
            popped_d      = hval_q;
            head_d        = idx_inc(head_q);
            front_d       = 1'b1;
            mem_req.re    = 1'b1;
            mem_req.raddr = head_d;
            state_d       = ST_READ;
          end else begin
            popped_d      = tval_q;
            tail_d        = idx_dec(tail_q);
            front_d       = 1'b0;
            mem_req.re    = 1'b1;
            mem_req.raddr = tail_d;
            state_d       = ST_READ;
          end
        end
      end
      ST_READ: begin
        popped_d = popped_q;
        if (front_q) begin
          hval_d = mem_rdata;
        end else begin
          tval_d = mem_rdata;
        end
        out_load = 1'b1;
        state_d  = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign full_d = !empty_d && (idx_inc(tail_d) == head_d);

  always_comb begin
    out_item_d.status     = status_d;
    out_item_d.popped     = widen(popped_d);
    out_item_d.head_value = empty_d ? '0 : widen(hval_d);
    out_item_d.tail_value = empty_d ? '0 : widen(tval_d);
    out_item_d.is_empty   = empty_d;
    out_item_d.is_full    = full_d;
  end

  assign out_valid_d = out_load || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      empty_q     <= 1'b1;
      front_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      empty_q     <= empty_d;
      front_q     <= front_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hval_q   <= hval_d;
    tval_q   <= tval_d;
    popped_q <= popped_d;
    if (out_load) begin
      out_item_q <= out_item_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  `CBD_ASSERT(a_read_out_free, (state_q == ST_READ) |-> !out_valid_q,
    "result register busy while a pop read is pending")
  `CBD_ASSERT_NEXT(a_read_one_cycle, state_q == ST_READ, state_q == ST_IDLE,
    "pop read lasted more than one cycle")
  `CBD_ASSERT(a_empty_idx_zero, empty_q |-> (head_q == '0 && tail_q == '0),
    "empty deque with nonzero indices")
  `CBD_ASSERT(a_no_rw_overlap, !(mem_req.we && mem_req.re),
    "slot write and read in the same cycle")

endmodule

`default_nettype wire
